>>> hw/rtl/kst_pkg.sv
// shared types, codes and constants for the keyed slot table
package kst_pkg;

   localparam int SLOTS_DEF  = 64;
   localparam int MODE_W     = 2;
   localparam int KEY_W      = 64;
   localparam int VAL_W      = 64;
   localparam int STATUS_W   = 2;
   localparam int SLOT_OUT_W = 6;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [VAL_W-1:0]      found_value;
      logic [SLOT_OUT_W-1:0] slot;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic clear;
      logic set_full;
      logic scan;
      logic ins_write;
      logic ins_finish;
      logic del_write;
      logic lkp_finish;
      logic set_miss;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              full;
      logic              hit;
      logic              scan_done;
      logic              clear_last;
      logic              out_free;
   } sts_type;

endpackage

>>> hw/rtl/kst_ram.sv
// generic single write port ram with registered read
module kst_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/kst_ctrl.sv
// sequencing state machine for the keyed slot table
module kst_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  kst_pkg::sts_type sts,
   output kst_pkg::cmd_type cmd
);

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_CHECK = 8'b0000_0100,
      S_SCAN  = 8'b0000_1000,
      S_APPLY = 8'b0001_0000,
      S_INS   = 8'b0010_0000,
      S_LRD   = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.mode == kst_pkg::MODE_INSERT && sts.full) begin
               cmd.set_full = 1'b1;
               state_in     = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            unique case (sts.mode)
               kst_pkg::MODE_INSERT: begin
                  cmd.ins_write = 1'b1;
                  state_in      = S_INS;
               end
               kst_pkg::MODE_DELETE: begin
                  cmd.del_write = sts.hit;
                  cmd.set_miss  = !sts.hit;
                  state_in      = S_DONE;
               end
               default: begin
                  // lookup, and the unused fourth code
                  if (sts.hit) begin
                     state_in = S_LRD;
                  end else begin
                     cmd.set_miss = 1'b1;
                     state_in     = S_DONE;
                  end
               end
            endcase
         end
         S_INS: begin
            cmd.ins_finish = 1'b1;
            state_in       = S_DONE;
         end
         S_LRD: begin
            cmd.lkp_finish = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_CHECK))
      else $error("accepted item did not start processing");

   a_apply_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY) |-> ($past(state_ff) == S_SCAN))
      else $error("update stage entered without a finished scan");

endmodule

>>> hw/rtl/kst_dp.sv
// slot memories, free list head, key scan and result registers
module kst_dp #(
   parameter int SLOTS = kst_pkg::SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  kst_pkg::req_type req_data,
   output kst_pkg::rsp_type rsp_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  kst_pkg::cmd_type cmd,
   output kst_pkg::sts_type sts
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int NEXT_W = $clog2(SLOTS + 1);
   localparam int EXT_W  = SLOT_W + kst_pkg::SLOT_OUT_W;

   kst_pkg::req_type req_ff;
   kst_pkg::rsp_type res_ff;
   kst_pkg::rsp_type rsp_data_ff;
   logic             rsp_valid_ff;
   logic [NEXT_W-1:0] free_head_ff;
   logic [NEXT_W-1:0] scan_addr_ff;
   logic              rd_pend_ff;
   logic [SLOT_W-1:0] rd_addr_ff;
   logic              hit_ff;
   logic [SLOT_W-1:0] hit_idx_ff;
   logic [SLOT_W-1:0] clr_addr_ff;

   logic [kst_pkg::KEY_W-1:0] key_q;
   logic [kst_pkg::VAL_W-1:0] val_q;
   logic                      map_q;
   logic [NEXT_W-1:0]         next_q;

   logic [SLOT_W-1:0] pop_slot;
   logic              scan_issue;
   logic              hit_now;
   logic              scan_last;
   logic [EXT_W-1:0]  cell_ext;
   logic [EXT_W-1:0]  hit_ext;
   logic [NEXT_W-1:0] next_head;

   logic              map_we;
   logic [SLOT_W-1:0] map_waddr;
   logic              next_we;
   logic [SLOT_W-1:0] next_waddr;
   logic [NEXT_W-1:0] next_wdata;

   assign pop_slot   = free_head_ff[SLOT_W-1:0];
   assign scan_issue = scan_addr_ff < NEXT_W'(SLOTS);
   assign hit_now    = rd_pend_ff && map_q && (key_q == req_ff.key);
   assign scan_last  = rd_pend_ff && (rd_addr_ff == SLOT_W'(SLOTS - 1));
   assign cell_ext   = EXT_W'(pop_slot);
   assign hit_ext    = EXT_W'(hit_idx_ff);
   assign next_head  = (next_q < NEXT_W'(SLOTS)) ? next_q : NEXT_W'(SLOTS);

   assign map_we     = cmd.clear || (cmd.ins_write && hit_ff) || cmd.ins_finish ||
                       cmd.del_write;
   assign map_waddr  = cmd.clear ? clr_addr_ff : (cmd.ins_finish ? pop_slot : hit_idx_ff);
   assign next_we    = cmd.clear || cmd.del_write;
   assign next_waddr = cmd.clear ? clr_addr_ff : hit_idx_ff;
   assign next_wdata = cmd.clear ? (NEXT_W'(clr_addr_ff) + NEXT_W'(1)) : free_head_ff;

   kst_ram #(.WIDTH(kst_pkg::KEY_W), .DEPTH(SLOTS)) u_key_ram (
      .clock (clock),
      .we    (cmd.ins_write),
      .waddr (pop_slot),
      .wdata (req_ff.key),
      .raddr (scan_addr_ff[SLOT_W-1:0]),
      .rdata (key_q)
   );

   kst_ram #(.WIDTH(kst_pkg::VAL_W), .DEPTH(SLOTS)) u_val_ram (
      .clock (clock),
      .we    (cmd.ins_write),
      .waddr (pop_slot),
      .wdata (req_ff.value),
      .raddr (hit_idx_ff),
      .rdata (val_q)
   );

   kst_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_map_ram (
      .clock (clock),
      .we    (map_we),
      .waddr (map_waddr),
      .wdata (cmd.ins_finish),
      .raddr (scan_addr_ff[SLOT_W-1:0]),
      .rdata (map_q)
   );

   kst_ram #(.WIDTH(NEXT_W), .DEPTH(SLOTS)) u_next_ram (
      .clock (clock),
      .we    (next_we),
      .waddr (next_waddr),
      .wdata (next_wdata),
      .raddr (pop_slot),
      .rdata (next_q)
   );

   // item and scan registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
         rd_pend_ff   <= 1'b0;
      end else if (cmd.accept) begin
         scan_addr_ff <= '0;
         rd_pend_ff   <= 1'b0;
      end else if (cmd.scan) begin
         // one slot read issued and one compared each cycle
         rd_pend_ff <= scan_issue;
         if (scan_issue) begin
            scan_addr_ff <= scan_addr_ff + NEXT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
      if (cmd.scan) begin
         rd_addr_ff <= scan_addr_ff[SLOT_W-1:0];
         hit_ff     <= hit_now;
         hit_idx_ff <= rd_addr_ff;
      end
   end

   // free list head and clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         clr_addr_ff  <= '0;
      end else begin
         if (cmd.clear) begin
            clr_addr_ff <= clr_addr_ff + SLOT_W'(1);
         end
         if (cmd.del_write) begin
            free_head_ff <= NEXT_W'(hit_idx_ff);
         end else if (cmd.ins_finish) begin
            free_head_ff <= next_head;
         end
      end
   end

   // result, then output register
   always_ff @(posedge clock) begin
      if (cmd.set_full) begin
         res_ff <= '{status: kst_pkg::ST_FULL, found_value: '0, slot: '0};
      end else if (cmd.set_miss) begin
         res_ff <= '{status: kst_pkg::ST_NOT_FOUND, found_value: '0, slot: '0};
      end else if (cmd.ins_finish) begin
         res_ff <= '{status: kst_pkg::ST_OK, found_value: '0,
                     slot: cell_ext[kst_pkg::SLOT_OUT_W-1:0]};
      end else if (cmd.del_write) begin
         res_ff <= '{status: kst_pkg::ST_OK, found_value: '0,
                     slot: hit_ext[kst_pkg::SLOT_OUT_W-1:0]};
      end else if (cmd.lkp_finish) begin
         res_ff <= '{status: kst_pkg::ST_OK, found_value: val_q,
                     slot: hit_ext[kst_pkg::SLOT_OUT_W-1:0]};
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_data = rsp_data_ff;
   assign rsp_valid = rsp_valid_ff;

   assign sts.mode       = req_ff.mode;
   assign sts.full       = free_head_ff >= NEXT_W'(SLOTS);
   assign sts.hit        = hit_ff;
   assign sts.scan_done  = hit_now || scan_last;
   assign sts.clear_last = clr_addr_ff == SLOT_W'(SLOTS - 1);
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      free_head_ff <= NEXT_W'(SLOTS))
      else $error("free list head beyond end marker");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_addr_ff <= NEXT_W'(SLOTS))
      else $error("scan address ran past the table");

   a_delete_needs_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.del_write |-> (hit_ff && $past(cmd.scan)))
      else $error("slot freed without a matching scan");

   a_insert_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_write |-> !sts.full)
      else $error("insert write with an empty free list");

endmodule

>>> hw/rtl/keyed_slot_table_with_free_list.sv
// keyed slot table with a linked free list: top level
// insert on a full table skips the key scan and goes from the check state to the response;
//   other items scan the keys one slot per cycle, until a key match or the last slot
// one item at a time: a new item is taken only after the last response is loaded for output
// reset: a clearing pass over every slot rebuilds the free list links and clears the
//   mapped bits; req_ready stays low during it
module keyed_slot_table_with_free_list #(
   parameter int SLOTS = kst_pkg::SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  kst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output kst_pkg::rsp_type rsp_data
);

   kst_pkg::cmd_type cmd;
   kst_pkg::sts_type sts;

   kst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   kst_dp #(.SLOTS(SLOTS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
